@@ hw/rtl/rxr_pkg.sv @@
// Shared constants, types and helpers for the ray / xy-rectangle intersect block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package rxr_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int WIDE_W    = 36;
    localparam int DIV_W     = 34;
    localparam int NUM_W     = 32;
    localparam int QUO_W     = 33;
    localparam int UV_W      = 17;
    localparam int DIV_CELLS = 32;
    localparam int TEX_CELLS = 17;
    localparam int STG_N     = 1 + DIV_CELLS + 1 + 3 + 1 + TEX_CELLS;
    localparam int ADDR_W    = 5;

    localparam logic [2:0] REG_X_MIN   = 3'd0;
    localparam logic [2:0] REG_Y_MIN   = 3'd1;
    localparam logic [2:0] REG_X_MAX   = 3'd2;
    localparam logic [2:0] REG_Y_MAX   = 3'd3;
    localparam logic [2:0] REG_PLANE_Z = 3'd4;

    localparam logic signed [COORD_W-1:0] ONE = 32'sh0001_0000;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
        logic [NUM_W-1:0] num;
        logic [QUO_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] y_max;
        logic signed [COORD_W-1:0] plane_z;
    } t_cfg;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic same;
        same = (v[WIDE_W-1:COORD_W-1] == '0) || (v[WIDE_W-1:COORD_W-1] == '1);
        if (same) begin
            return v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rxr_cfg.sv @@
// APB register file for rectangle edges and plane height.
// Depends on rxr_pkg for register indexes and the t_cfg struct.
`default_nettype none
module rxr_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rxr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output rxr_pkg::t_cfg                  o_cfg
);

    rxr_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx  = paddr[rxr_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min   <= '0;
            r_cfg.y_min   <= '0;
            r_cfg.x_max   <= rxr_pkg::ONE;
            r_cfg.y_max   <= rxr_pkg::ONE;
            r_cfg.plane_z <= '0;
        end else if (w_wr) begin
            case (w_idx)
                rxr_pkg::REG_X_MIN:   r_cfg.x_min   <= pwdata;
                rxr_pkg::REG_Y_MIN:   r_cfg.y_min   <= pwdata;
                rxr_pkg::REG_X_MAX:   r_cfg.x_max   <= pwdata;
                rxr_pkg::REG_Y_MAX:   r_cfg.y_max   <= pwdata;
                rxr_pkg::REG_PLANE_Z: r_cfg.plane_z <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rxr_pkg::REG_X_MIN:   prdata = r_cfg.x_min;
            rxr_pkg::REG_Y_MIN:   prdata = r_cfg.y_min;
            rxr_pkg::REG_X_MAX:   prdata = r_cfg.x_max;
            rxr_pkg::REG_Y_MAX:   prdata = r_cfg.y_max;
            rxr_pkg::REG_PLANE_Z: prdata = r_cfg.plane_z;
            default:              prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/rxr_div_cell.sv @@
// One restoring-division cell: shift in a numerator bit, compare, subtract.
// Depends on rxr_pkg for the t_div struct.
`default_nettype none
module rxr_div_cell (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  rxr_pkg::t_div i_d,
    output rxr_pkg::t_div o_d
);

    rxr_pkg::t_div             r_d;
    rxr_pkg::t_div             n_d;
    logic [rxr_pkg::DIV_W-1:0] w_shift;
    logic                      w_ge;

    always_comb begin
        w_shift  = {i_d.rem[rxr_pkg::DIV_W-2:0], i_d.num[rxr_pkg::NUM_W-1]};
        w_ge     = (w_shift >= i_d.den);
        n_d.rem  = w_ge ? (w_shift - i_d.den) : w_shift;
        n_d.den  = i_d.den;
        n_d.num  = {i_d.num[rxr_pkg::NUM_W-2:0], 1'b0};
        n_d.quo  = {i_d.quo[rxr_pkg::QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

@@ hw/rtl/rxr_axis.sv @@
// Per-axis hit coordinate: origin + floor(t * dir / 2^16), offset clamped, three stages.
// Depends on rxr_pkg for widths.
`default_nettype none
module rxr_axis (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [rxr_pkg::QUO_W-1:0]         i_tmag,
    input  wire logic                              i_tneg,
    input  wire logic signed [rxr_pkg::COORD_W-1:0] i_dir,
    input  wire logic signed [rxr_pkg::COORD_W-1:0] i_org,
    output logic signed [rxr_pkg::WIDE_W-1:0]      o_coord
);

    localparam logic [33:0] LIM = 34'h2_0000_0000;

    logic [31:0]                       w_dmag;
    logic [63:0]                       w_prod;
    logic [63:0]                       r_prod;
    logic                              r_sign1;
    logic signed [rxr_pkg::COORD_W-1:0] r_org1;

    logic [47:0]                       w_q;
    logic                              w_big;
    logic                              w_inc;
    logic [33:0]                       w_sum;
    logic [33:0]                       r_mag;
    logic                              r_sign2;
    logic signed [rxr_pkg::COORD_W-1:0] r_org2;

    logic signed [34:0]                w_off;
    logic signed [rxr_pkg::WIDE_W-1:0] r_coord;

    always_comb begin
        w_dmag = i_dir[31] ? (32'd0 - i_dir) : i_dir;
        w_prod = i_tmag[32] ? {w_dmag, 32'd0} : (i_tmag[31:0] * w_dmag);
        w_q    = r_prod[63:16];
        w_big  = |w_q[47:33];
        w_inc  = r_sign1 & (|r_prod[15:0]);
        w_sum  = {1'b0, w_q[32:0]} + {33'd0, w_inc};
        w_off  = r_sign2 ? (35'sd0 - $signed({1'b0, r_mag})) : $signed({1'b0, r_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= w_prod;
            r_sign1 <= i_tneg ^ i_dir[31];
            r_org1  <= i_org;
            r_mag   <= w_big ? LIM : w_sum;
            r_sign2 <= r_sign1;
            r_org2  <= r_org1;
            r_coord <= $signed({{4{r_org2[31]}}, r_org2}) + $signed({w_off[34], w_off});
        end
    end

    assign o_coord = r_coord;

endmodule
`default_nettype wire

@@ hw/rtl/ray_xy_rectangle_intersect.sv @@
// Top level: ray against axis-aligned rectangle in plane z = plane_z, Q16.16.
// Depends on rxr_pkg, rxr_cfg, rxr_div_cell and rxr_axis.
//
//  channel   dir  width  contents
//  s_*       in   256    one ray per transaction
//  m_*       out  168+2  one result per transaction
//  APB       in/out 32   five registers at byte addresses 0..16
//
// One ray per cycle while the output does not stall; 56 register stages.
// The pipe depth is set mostly by the 32-cell distance divider and the 17-cell texture dividers.
// Synchronous active-low reset clears the valid chain and output valid, and resets the APB registers.
// A stalled output holds the pipe only when its last cell holds a result.
`default_nettype none
module ray_xy_rectangle_intersect (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, dist_min, dist_max
    input  wire logic [255:0]               s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // hit_dist, tex_u, tex_v, point_x, point_y, point_z, zero pad
    output logic [167:0]                    m_tdata,
    // hit, front_face
    output logic [1:0]                      m_tuser,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rxr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    localparam int LAST = rxr_pkg::STG_N - 1;
    localparam int DC   = rxr_pkg::DIV_CELLS;
    localparam int TC   = rxr_pkg::TEX_CELLS;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] dmin;
        logic signed [31:0] dmax;
    } t_ray;

    typedef struct packed {
        t_ray ray;
        logic ovf;
        logic neg;
        logic dzero;
    } t_dpay;

    typedef struct packed {
        logic signed [33:0] t;
        logic               miss;
        logic               front;
    } t_apay;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hdist;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               front;
        logic               uz;
        logic               vz;
    } t_opay;

    rxr_pkg::t_cfg w_cfg;

    logic                     w_en;
    logic                     w_acc;
    logic [rxr_pkg::STG_N-1:0] r_v;
    t_ray                     r_in;

    logic signed [32:0]       w_num;
    logic [32:0]              w_n;
    logic [31:0]              w_d;
    rxr_pkg::t_div            w_seed;
    t_dpay                    w_dpay0;

    rxr_pkg::t_div            w_dq [DC];
    t_dpay                    r_dpay [DC];

    logic [32:0]              w_q;
    logic signed [33:0]       w_t;
    logic                     w_miss;
    logic [32:0]              r_tq;
    logic                     r_tneg;
    t_ray                     r_tray;
    t_apay                    r_ta;
    t_apay                    r_apay [3];

    logic signed [35:0]       w_cx;
    logic signed [35:0]       w_cy;
    logic signed [35:0]       w_cz;

    logic signed [35:0]       w_x0;
    logic signed [35:0]       w_x1;
    logic signed [35:0]       w_y0;
    logic signed [35:0]       w_y1;
    logic signed [35:0]       w_offx;
    logic signed [35:0]       w_offy;
    logic signed [35:0]       w_spanx;
    logic signed [35:0]       w_spany;
    logic                     w_hit;
    rxr_pkg::t_div            r_useed;
    rxr_pkg::t_div            r_vseed;
    t_opay                    r_opay;

    rxr_pkg::t_div            w_uq [TC];
    rxr_pkg::t_div            w_vq [TC];
    t_opay                    r_xpay [TC];

    t_opay                    w_last;
    logic [16:0]              w_u;
    logic [16:0]              w_vv;
    logic                     r_ov;
    logic [167:0]             r_tdata;
    logic [1:0]               r_tuser;

    rxr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_en     = !(r_ov && !m_tready && r_v[LAST]);
    assign s_tready = w_en;
    assign w_acc    = s_tvalid & w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[rxr_pkg::STG_N-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in.ox   <= s_tdata[31:0];
            r_in.oy   <= s_tdata[63:32];
            r_in.oz   <= s_tdata[95:64];
            r_in.dx   <= s_tdata[127:96];
            r_in.dy   <= s_tdata[159:128];
            r_in.dz   <= s_tdata[191:160];
            r_in.dmin <= s_tdata[223:192];
            r_in.dmax <= s_tdata[255:224];
        end
    end

    always_comb begin
        w_num         = $signed({w_cfg.plane_z[31], w_cfg.plane_z})
                      - $signed({r_in.oz[31], r_in.oz});
        w_n           = w_num[32] ? (33'd0 - w_num) : w_num;
        w_d           = r_in.dz[31] ? (32'd0 - r_in.dz) : r_in.dz;
        w_seed.rem    = {17'd0, w_n[32:16]};
        w_seed.den    = {2'd0, w_d};
        w_seed.num    = {w_n[15:0], 16'd0};
        w_seed.quo    = '0;
        w_dpay0.ray   = r_in;
        w_dpay0.ovf   = ({15'd0, w_n[32:16]} >= w_d);
        w_dpay0.neg   = w_num[32] ^ r_in.dz[31];
        w_dpay0.dzero = (r_in.dz == '0);
    end

    for (genvar k = 0; k < DC; k++) begin : g_div
        if (k == 0) begin : g_first
            rxr_div_cell u_cell (.i_clk(i_clk), .i_en(w_en), .i_d(w_seed), .o_d(w_dq[k]));
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dpay[k] <= w_dpay0;
                end
            end
        end else begin : g_next
            rxr_div_cell u_cell (.i_clk(i_clk), .i_en(w_en), .i_d(w_dq[k-1]), .o_d(w_dq[k]));
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dpay[k] <= r_dpay[k-1];
                end
            end
        end
    end

    always_comb begin
        w_q    = r_dpay[DC-1].ovf ? {1'b1, 32'd0} : {1'b0, w_dq[DC-1].quo[31:0]};
        w_t    = r_dpay[DC-1].neg ? (34'sd0 - $signed({1'b0, w_q})) : $signed({1'b0, w_q});
        w_miss = r_dpay[DC-1].dzero
               || (w_t < $signed({{2{r_dpay[DC-1].ray.dmin[31]}}, r_dpay[DC-1].ray.dmin}))
               || (w_t > $signed({{2{r_dpay[DC-1].ray.dmax[31]}}, r_dpay[DC-1].ray.dmax}));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tq       <= w_q;
            r_tneg     <= r_dpay[DC-1].neg;
            r_tray     <= r_dpay[DC-1].ray;
            r_ta.t     <= w_t;
            r_ta.miss  <= w_miss;
            r_ta.front <= r_dpay[DC-1].ray.dz[31];
            r_apay[0]  <= r_ta;
            r_apay[1]  <= r_apay[0];
            r_apay[2]  <= r_apay[1];
        end
    end

    rxr_axis u_ax_x (.i_clk(i_clk), .i_en(w_en), .i_tmag(r_tq), .i_tneg(r_tneg),
                     .i_dir(r_tray.dx), .i_org(r_tray.ox), .o_coord(w_cx));
    rxr_axis u_ax_y (.i_clk(i_clk), .i_en(w_en), .i_tmag(r_tq), .i_tneg(r_tneg),
                     .i_dir(r_tray.dy), .i_org(r_tray.oy), .o_coord(w_cy));
    rxr_axis u_ax_z (.i_clk(i_clk), .i_en(w_en), .i_tmag(r_tq), .i_tneg(r_tneg),
                     .i_dir(r_tray.dz), .i_org(r_tray.oz), .o_coord(w_cz));

    always_comb begin
        w_x0    = $signed({{4{w_cfg.x_min[31]}}, w_cfg.x_min});
        w_x1    = $signed({{4{w_cfg.x_max[31]}}, w_cfg.x_max});
        w_y0    = $signed({{4{w_cfg.y_min[31]}}, w_cfg.y_min});
        w_y1    = $signed({{4{w_cfg.y_max[31]}}, w_cfg.y_max});
        w_offx  = w_cx - w_x0;
        w_offy  = w_cy - w_y0;
        w_spanx = w_x1 - w_x0;
        w_spany = w_y1 - w_y0;
        w_hit   = !r_apay[2].miss && (w_cx >= w_x0) && (w_cx <= w_x1)
                  && (w_cy >= w_y0) && (w_cy <= w_y1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_useed.rem  <= {1'b0, w_offx[33:1]};
            r_useed.den  <= w_spanx[33:0];
            r_useed.num  <= {w_offx[0], 31'd0};
            r_useed.quo  <= '0;
            r_vseed.rem  <= {1'b0, w_offy[33:1]};
            r_vseed.den  <= w_spany[33:0];
            r_vseed.num  <= {w_offy[0], 31'd0};
            r_vseed.quo  <= '0;
            r_opay.hit   <= w_hit;
            r_opay.hdist <= rxr_pkg::sat_coord($signed({{2{r_apay[2].t[33]}}, r_apay[2].t}));
            r_opay.px    <= rxr_pkg::sat_coord(w_cx);
            r_opay.py    <= rxr_pkg::sat_coord(w_cy);
            r_opay.pz    <= rxr_pkg::sat_coord(w_cz);
            r_opay.front <= r_apay[2].front;
            r_opay.uz    <= (w_spanx == '0);
            r_opay.vz    <= (w_spany == '0);
        end
    end

    for (genvar k = 0; k < TC; k++) begin : g_tex
        if (k == 0) begin : g_first
            rxr_div_cell u_ucell (.i_clk(i_clk), .i_en(w_en), .i_d(r_useed), .o_d(w_uq[k]));
            rxr_div_cell u_vcell (.i_clk(i_clk), .i_en(w_en), .i_d(r_vseed), .o_d(w_vq[k]));
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_xpay[k] <= r_opay;
                end
            end
        end else begin : g_next
            rxr_div_cell u_ucell (.i_clk(i_clk), .i_en(w_en), .i_d(w_uq[k-1]), .o_d(w_uq[k]));
            rxr_div_cell u_vcell (.i_clk(i_clk), .i_en(w_en), .i_d(w_vq[k-1]), .o_d(w_vq[k]));
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_xpay[k] <= r_xpay[k-1];
                end
            end
        end
    end

    always_comb begin
        w_last = r_xpay[TC-1];
        w_u    = w_last.uz ? 17'd0 : w_uq[TC-1].quo[16:0];
        w_vv   = w_last.vz ? 17'd0 : w_vq[TC-1].quo[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!r_ov || m_tready) begin
            r_ov <= r_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || m_tready) begin
            if (w_last.hit) begin
                r_tdata <= {6'd0, w_last.pz, w_last.py, w_last.px, w_vv, w_u, w_last.hdist};
                r_tuser <= {w_last.front, 1'b1};
            end else begin
                r_tdata <= '0;
                r_tuser <= '0;
            end
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_tdata;
    assign m_tuser  = r_tuser;

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> (r_v[LAST] && r_ov))
        else $error("pipe stalled without a pending result");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> r_v[0])
        else $error("accepted ray did not enter the pipe");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("miss result carries nonzero fields");
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0])
        |-> (m_tdata[48:32] <= 17'h10000 && m_tdata[65:49] <= 17'h10000))
        else $error("texture coordinate above one");
`endif

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for ray_xy_rectangle_intersect: streams rays through the block, predicts each
// result in SystemVerilog arithmetic and compares field by field. Depends on rxr_pkg and the RTL.
`default_nettype none
module testbench;

    typedef struct packed {
        logic signed [31:0] dmax, dmin, dz, dy, dx, oz, oy, ox;
    } t_ray;

    typedef struct {
        logic               hit;
        logic signed [31:0] hdist;
        logic [16:0]        u, v;
        logic signed [31:0] px, py, pz;
        logic               front;
    } t_isect;

    logic         i_clk, i_rst_n;
    logic         s_tvalid, s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid, m_tready;
    logic [167:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel, penable, pwrite;
    logic [rxr_pkg::ADDR_W-1:0] paddr;
    logic [31:0]  pwdata, prdata;
    logic         pready;

    ray_xy_rectangle_intersect dut (.*);

    logic signed [31:0] rect[5];
    t_ray   ray_q[$];
    t_isect isect_q[$];
    int     errors = 0;
    int     src_idle = 34, snk_idle = 46;
    int     hold_off = 0;
    logic   s_acc = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint mag(longint a);
        return a < 0 ? -a : a;
    endfunction

    // floor(a*b/2^16), magnitude clamped at 2^33
    function automatic longint mul_q(longint a, longint b);
        logic [127:0] p;
        logic [127:0] q;
        longint       r;
        logic         neg;
        neg = (a < 0) != (b < 0);
        p = 128'(mag(a)) * 128'(mag(b));
        q = p >> 16;
        if (q >= (128'(1) << 33)) r = longint'(1) << 33;
        else begin
            r = longint'(q);
            if (neg && p[15:0] != 0) r = r + 1;
            if (r > (longint'(1) << 33)) r = longint'(1) << 33;
        end
        return neg ? -r : r;
    endfunction

    function automatic longint div_q(longint num, longint den);
        logic [127:0] q;
        longint       r;
        q = (128'(mag(num)) << 16) / 128'(mag(den));
        r = q >= (128'(1) << 32) ? longint'(1) << 32 : longint'(q);
        return ((num < 0) != (den < 0)) ? -r : r;
    endfunction

    function automatic logic [16:0] tex_q(longint off, longint span);
        logic [127:0] q;
        if (span <= 0 || off < 0) return 0;
        q = (128'(off) << 16) / 128'(span);
        return q[16:0];
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic t_isect predict_hit(t_ray r);
        t_isect e;
        longint t, x, y;
        longint x0, y0, x1, y1;
        x0 = rect[rxr_pkg::REG_X_MIN]; y0 = rect[rxr_pkg::REG_Y_MIN];
        x1 = rect[rxr_pkg::REG_X_MAX]; y1 = rect[rxr_pkg::REG_Y_MAX];
        e = '{default: 0};
        if (r.dz == 0) return e;
        t = div_q(longint'(rect[rxr_pkg::REG_PLANE_Z]) - r.oz, r.dz);
        if (t < r.dmin || t > r.dmax) return e;
        x = r.ox + mul_q(t, r.dx);
        y = r.oy + mul_q(t, r.dy);
        if (x < x0 || x > x1 || y < y0 || y > y1) return e;
        e.hit   = 1;
        e.hdist = clamp32(t);
        e.u     = tex_q(x - x0, x1 - x0);
        e.v     = tex_q(y - y0, y1 - y0);
        e.px    = clamp32(x);
        e.py    = clamp32(y);
        e.pz    = clamp32(r.oz + mul_q(t, r.dz));
        e.front = r.dz < 0;
        return e;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic signed [31:0] val);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        rect[idx] = val;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_acc) begin
            if (ray_q.size() > 0 && $urandom_range(99) >= src_idle) begin
                s_tvalid <= 1;
                s_tdata  <= ray_q[0];
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        s_acc <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            isect_q.push_back(predict_hit(t_ray'(s_tdata)));
            void'(ray_q.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= $urandom_range(99) >= snk_idle;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (isect_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result %h %h", $time, m_tuser, m_tdata);
            end else begin
                t_isect e;
                e = isect_q.pop_front();
                if (m_tuser[0] !== e.hit || m_tuser[1] !== e.front
                    || m_tdata[31:0] !== e.hdist || m_tdata[48:32] !== e.u
                    || m_tdata[65:49] !== e.v || m_tdata[97:66] !== e.px
                    || m_tdata[129:98] !== e.py || m_tdata[161:130] !== e.pz) begin
                    errors++;
                    $display("%0t mismatch: expected hit=%b ff=%b t=%h u=%h v=%h p=%h %h %h",
                             $time, e.hit, e.front, e.hdist, e.u, e.v, e.px, e.py, e.pz);
                    $display("%0t           actual   hit=%b ff=%b t=%h u=%h v=%h p=%h %h %h",
                             $time, m_tuser[0], m_tuser[1], m_tdata[31:0], m_tdata[48:32],
                             m_tdata[65:49], m_tdata[97:66], m_tdata[129:98], m_tdata[161:130]);
                end
            end
        end
    end

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    // ray aimed at the rectangle: pick a target point, a t and a direction
    function automatic t_ray aimed_ray();
        t_ray   r;
        longint tx, ty, t, w, h;
        w  = longint'(rect[rxr_pkg::REG_X_MAX]) - rect[rxr_pkg::REG_X_MIN];
        h  = longint'(rect[rxr_pkg::REG_Y_MAX]) - rect[rxr_pkg::REG_Y_MIN];
        tx = rect[rxr_pkg::REG_X_MIN] + (w > 0 ? longint'($urandom) % (w + 1) : 0);
        ty = rect[rxr_pkg::REG_Y_MIN] + (h > 0 ? longint'($urandom) % (h + 1) : 0);
        t  = $urandom_range(32'h4_0000, 32'h100);
        r.dx = $signed($urandom_range(32'h4_0000)) - 32'sh2_0000;
        r.dy = $signed($urandom_range(32'h4_0000)) - 32'sh2_0000;
        r.dz = $signed($urandom_range(32'h4_0000)) - 32'sh2_0000;
        r.ox = clamp32(tx - ((t * r.dx) >>> 16));
        r.oy = clamp32(ty - ((t * r.dy) >>> 16));
        r.oz = clamp32(longint'(rect[rxr_pkg::REG_PLANE_Z]) - ((t * r.dz) >>> 16));
        r.dmin = $urandom_range(3) == 0 ? rnd32() : 0;
        r.dmax = $urandom_range(3) == 0 ? rnd32() : 32'sh7FFF_FFFF;
        return r;
    endfunction

    task automatic drain(int extra);
        while (ray_q.size() > 0 || isect_q.size() > 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        t_ray r;
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; m_tready = 0;
        rect[rxr_pkg::REG_X_MIN] = 0; rect[rxr_pkg::REG_Y_MIN] = 0;
        rect[rxr_pkg::REG_X_MAX] = rxr_pkg::ONE; rect[rxr_pkg::REG_Y_MAX] = rxr_pkg::ONE;
        rect[rxr_pkg::REG_PLANE_Z] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed rays on the reset rectangle
        r = '{ox: 32'sh8000, oy: 32'sh8000, oz: rxr_pkg::ONE, dx: 0, dy: 0,
              dz: -rxr_pkg::ONE, dmin: 0, dmax: 32'sh7FFF_FFFF, default: 0};
        ray_q.push_back(r);
        r.dz = 0;                                     ray_q.push_back(r);
        r.dz = rxr_pkg::ONE; r.oz = -rxr_pkg::ONE;    ray_q.push_back(r);
        r.dmax = 32'sh8000;                           ray_q.push_back(r);
        r.dmin = 32'sh2_0000; r.dmax = rxr_pkg::ONE;  ray_q.push_back(r);
        r = '{ox: 0, oy: rxr_pkg::ONE, oz: rxr_pkg::ONE, dx: 0, dy: 0, dz: -rxr_pkg::ONE,
              dmin: 0, dmax: rxr_pkg::ONE, default: 0};
        ray_q.push_back(r);
        r.ox = rxr_pkg::ONE + 1;                      ray_q.push_back(r);
        r.ox = rxr_pkg::ONE; r.oy = 0;                ray_q.push_back(r);
        r.oy = -1;                                    ray_q.push_back(r);
        r = '{ox: 0, oy: 0, oz: 32'sh7FFF_FFFF, dx: 32'sh7FFF_FFFF,
              dy: 32'sh8000_0000, dz: 1, dmin: 32'sh8000_0000,
              dmax: 32'sh7FFF_FFFF, default: 0};
        ray_q.push_back(r);
        r.oz = 32'sh8000_0000; r.dz = 32'sh8000_0000; ray_q.push_back(r);
        r = '{ox: 32'sh8000_0000, oy: 32'sh7FFF_FFFF, oz: 32'sh8000_0000,
              dx: 32'sh7FFF_FFFF, dy: 32'sh8000_0000, dz: 32'sh7FFF_FFFF,
              dmin: 32'sh8000_0000, dmax: 32'sh7FFF_FFFF, default: 0};
        ray_q.push_back(r);
        r = '{default: 32'sh7FFF_FFFF}; ray_q.push_back(r);
        r = '{default: 32'sh8000_0000}; ray_q.push_back(r);
        r = '{default: 32'shFFFF_FFFF}; ray_q.push_back(r);
        drain(60);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(rxr_pkg::REG_X_MIN, -rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_Y_MIN, -rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_X_MAX, 3 * rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_Y_MAX, 2 * rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_PLANE_Z, rxr_pkg::ONE); end
                1: begin write_reg(rxr_pkg::REG_X_MIN, 32'sh8000_0000);
                         write_reg(rxr_pkg::REG_X_MAX, 32'sh7FFF_FFFF);
                         write_reg(rxr_pkg::REG_Y_MIN, 32'sh8000_0000);
                         write_reg(rxr_pkg::REG_Y_MAX, 32'sh7FFF_FFFF);
                         write_reg(rxr_pkg::REG_PLANE_Z, 32'sh7FFF_FFFF); end
                2: begin write_reg(rxr_pkg::REG_X_MIN, rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_X_MAX, rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_Y_MIN, 0);
                         write_reg(rxr_pkg::REG_Y_MAX, 0);
                         write_reg(rxr_pkg::REG_PLANE_Z, 32'sh8000_0000); end
                3: begin write_reg(rxr_pkg::REG_X_MIN, 2 * rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_X_MAX, -rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_PLANE_Z, -5 * rxr_pkg::ONE); end
                4: for (int k = 0; k < 5; k++) write_reg(3'(k), $urandom);
                5: begin write_reg(rxr_pkg::REG_X_MIN, -4 * rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_X_MAX, 4 * rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_Y_MIN, -3 * rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_Y_MAX, 5 * rxr_pkg::ONE);
                         write_reg(rxr_pkg::REG_PLANE_Z, -2 * rxr_pkg::ONE); end
                default: ;
            endcase
            if (phase < 2)      begin src_idle = 34; snk_idle = 46; end
            else if (phase < 4) begin src_idle = 46; snk_idle = 34; end
            else                begin src_idle = 0;  snk_idle = 0;  end
            if (phase == 5) hold_off = 300;
            for (int n = 0; n < 320; n++) begin
                if ($urandom_range(9) < 7) ray_q.push_back(aimed_ray());
                else begin
                    for (int k = 0; k < 8; k++) r[k*32 +: 32] = rnd32();
                    ray_q.push_back(r);
                end
            end
            drain(60);
        end

        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/rxr_pkg.sv
hw/rtl/rxr_cfg.sv
hw/rtl/rxr_div_cell.sv
hw/rtl/rxr_axis.sv
hw/rtl/ray_xy_rectangle_intersect.sv
tb/sv/testbench.sv
